// ----- hdl/assert_macros.svh -----
// Assertion helpers for the 1-Wire slot timer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is active.
`define OWT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owt assertion failed");

// Next-cycle implication, off while reset is active.
`define OWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owt assertion failed");

`endif

// ----- hdl/owt_pkg.sv -----
`default_nettype none

package owt_pkg;

    localparam int REG_W         = 10;
    localparam int REG_COUNT     = 8;
    localparam int REG_SEL_W     = $clog2(REG_COUNT);
    localparam int CFG_IDX_W     = 8;
    localparam int COUNTER_BITS  = 10;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int CMP_W         = (COUNTER_BITS > REG_W) ? COUNTER_BITS : REG_W;

    typedef logic [REG_W-1:0] t_cfg_word;
    typedef t_cfg_word [REG_COUNT-1:0] t_cfg_array;

    // Register indexes
    localparam logic [REG_SEL_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_SHORT_LOW     = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_LONG_LOW      = 3'd4;
    localparam logic [REG_SEL_W-1:0] REG_WRITE_ONE_TAIL  = 3'd5;
    localparam logic [REG_SEL_W-1:0] REG_WRITE_ZERO_TAIL = 3'd6;
    localparam logic [REG_SEL_W-1:0] REG_SAMPLE_WAIT   = 3'd7;

    localparam t_cfg_array CFG_RESET = '{
        10'd9,   // sample wait
        10'd10,  // write zero tail
        10'd64,  // write one tail
        10'd60,  // long low
        10'd6,   // short low
        10'd410, // reset tail
        10'd70,  // presence wait
        10'd480  // reset low
    };

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_RESET = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_value;
    } t_owt_result;

    typedef struct packed {
        logic busy;
    } t_owt_status;

endpackage

`default_nettype wire

// ----- hdl/onewire_master_slot_timer_unit.sv -----
`default_nettype none
`include "assert_macros.svh"

// 1-Wire bus master paced by ticks. Every input transaction is one time tick
// carrying the sampled bus level and an optional command (reset with presence
// detect, byte write LSB first, byte read LSB first); every tick yields exactly
// one output transaction with drive_low, busy, a one-tick done pulse, the
// presence flag and the last byte read. Commands that arrive while an
// operation runs are ignored. The bus is only pulled low or released, never
// driven high. Throughput is one tick per clock cycle while the output side
// does not stall; a tick goes from the input register through the
// phase/counter logic into the output register. While a result waits, the
// input register takes one more tick and then holds it, so the input stalls
// until the result is taken.
// Timing registers 0..7 (reset low, presence wait, reset tail, short low,
// long low, write-one tail, write-zero tail, sample wait) are written through
// the config port, index out of range is dropped, and a value of zero runs as
// one tick; write them only while no transaction is in flight. A new value
// applies from the next tick on, also in the middle of an operation.
module onewire_master_slot_timer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Tick input
    input  wire logic                          i_in_valid,
    output      logic                          o_in_ready,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [7:0]                    i_write_value,
    input  wire logic                          i_line_level,
    // Result output
    output      logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    output      logic                          o_drive_low,
    output      logic                          o_busy_res,
    output      logic                          o_done_res,
    output      logic                          o_presence,
    output      logic [7:0]                    o_read_value,
    // Configuration writes
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [owt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [owt_pkg::REG_W-1:0]     i_cfg_data
);
    import owt_pkg::*;

    t_cfg_array  w_cfg;
    t_owt_result w_res;
    t_owt_status w_status;
    logic        w_adv;

    // Input register
    logic        r_in_valid;
    t_mode       r_mode;
    logic [7:0]  r_write_value;
    logic        r_line_level;

    // Output register
    logic        r_out_valid;
    logic        r_drive_low;
    logic        r_busy_res;
    logic        r_done_res;
    logic        r_presence;
    logic [7:0]  r_read_value;

    // Advance the held tick when the output slot is free or being drained.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    owt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    owt_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_mode        (r_mode),
        .i_write_value (r_write_value),
        .i_line_level  (r_line_level),
        .i_cfg         (w_cfg),
        .o_res         (w_res),
        .o_status      (w_status)
    );

    // Hold a tick until the core takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_mode        <= t_mode'(i_mode);
            r_write_value <= i_write_value;
            r_line_level  <= i_line_level;
        end
    end

    // Capture the result of each advanced tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_read_value <= '0;
        end else if (w_adv) begin
            r_out_valid  <= 1'b1;
            r_read_value <= w_res.read_value;
        end else if (i_out_ready) begin
            r_out_valid  <= 1'b0;
        end
        if (w_adv) begin
            r_drive_low <= w_res.drive_low;
            r_busy_res  <= w_res.busy;
            r_done_res  <= w_res.done;
            r_presence  <= w_res.presence;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_drive_low  = r_drive_low;
    assign o_busy_res   = r_busy_res;
    assign o_done_res   = r_done_res;
    assign o_presence   = r_presence;
    assign o_read_value = r_read_value;

    // A finishing tick leaves the sequencer idle.
    `OWT_ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n, w_adv && w_res.done, !w_status.busy)
    // The read byte only moves on a finishing tick.
    `OWT_ASSERT_NEXT(a_read_value_hold, i_clk, i_rst_n, w_adv && !w_res.done,
        $stable(r_read_value))
    // A plain tick while idle starts nothing.
    `OWT_ASSERT_NEXT(a_idle_tick_stays_idle, i_clk, i_rst_n,
        w_adv && !w_status.busy && (r_mode == MODE_TICK), !w_status.busy)

endmodule

`default_nettype wire

// ----- hdl/owt_cfg_regs.sv -----
`default_nettype none

module owt_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [owt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [owt_pkg::REG_W-1:0]     i_cfg_data,
    output      logic                          o_cfg_ready,
    output      owt_pkg::t_cfg_array           o_cfg
);
    import owt_pkg::*;

    t_cfg_array r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Drop writes past the last register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(REG_COUNT))) begin
            r_cfg[i_cfg_index[REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/owt_core.sv -----
`default_nettype none

module owt_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_adv,
    input  wire owt_pkg::t_mode         i_mode,
    input  wire logic [7:0]             i_write_value,
    input  wire logic                   i_line_level,
    input  wire owt_pkg::t_cfg_array    i_cfg,
    output owt_pkg::t_owt_result        o_res,
    output owt_pkg::t_owt_status        o_status
);
    import owt_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_W_LOW,
        PH_W_TAIL,
        PH_R_LOW,
        PH_R_WAIT,
        PH_R_REC
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [COUNTER_BITS-1:0] r_tick, n_tick;
    logic [BIT_IDX_W-1:0]    r_bit, n_bit;
    logic [7:0]              r_shift, n_shift;
    logic                    r_pres, n_pres;
    logic [7:0]              r_last, n_last;

    t_phase                  w_phase;
    logic [COUNTER_BITS-1:0] w_tick, w_tick_inc;
    logic [BIT_IDX_W-1:0]    w_bit;
    logic [7:0]              w_shift;
    logic                    w_cur;
    t_cfg_word               w_len_raw, w_len;
    logic                    w_expire, w_last_bit, w_done;

    always_comb begin
        // Start a new operation in the tick its command arrives.
        w_phase = r_phase;
        w_tick  = r_tick;
        w_bit   = r_bit;
        w_shift = r_shift;
        if (r_phase == PH_IDLE && i_mode != MODE_TICK) begin
            w_tick = '0;
            w_bit  = '0;
            case (i_mode)
                MODE_RESET: w_phase = PH_RST_LOW;
                MODE_WRITE: begin
                    w_shift = i_write_value;
                    w_phase = PH_W_LOW;
                end
                default: begin
                    w_shift = '0;
                    w_phase = PH_R_LOW;
                end
            endcase
        end

        w_cur = w_shift[w_bit];
        case (w_phase)
            PH_RST_LOW:  w_len_raw = i_cfg[REG_RESET_LOW];
            PH_RST_WAIT: w_len_raw = i_cfg[REG_PRESENCE_WAIT];
            PH_RST_TAIL: w_len_raw = i_cfg[REG_RESET_TAIL];
            PH_W_LOW:    w_len_raw = w_cur ? i_cfg[REG_SHORT_LOW] : i_cfg[REG_LONG_LOW];
            PH_W_TAIL:   w_len_raw = w_cur ? i_cfg[REG_WRITE_ONE_TAIL]
                                           : i_cfg[REG_WRITE_ZERO_TAIL];
            PH_R_LOW:    w_len_raw = i_cfg[REG_SHORT_LOW];
            PH_R_WAIT:   w_len_raw = i_cfg[REG_SAMPLE_WAIT];
            PH_R_REC:    w_len_raw = i_cfg[REG_LONG_LOW];
            default:     w_len_raw = '0;
        endcase
        // A zero length runs as one tick.
        w_len = (w_len_raw == '0) ? REG_W'(1) : w_len_raw;

        w_tick_inc = w_tick + COUNTER_BITS'(1);
        w_expire   = CMP_W'(w_tick_inc) >= CMP_W'(w_len);
        w_last_bit = w_bit == BIT_IDX_W'(BITS_PER_BYTE - 1);

        n_phase = w_phase;
        n_tick  = w_tick;
        n_bit   = w_bit;
        n_shift = w_shift;
        n_pres  = r_pres;
        n_last  = r_last;
        w_done  = 1'b0;

        if (w_phase != PH_IDLE) begin
            n_tick = w_expire ? '0 : w_tick_inc;
            if (w_expire) begin
                case (w_phase)
                    PH_RST_LOW:  n_phase = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        n_pres  = ~i_line_level;
                        n_phase = PH_RST_TAIL;
                    end
                    PH_RST_TAIL: begin
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end
                    PH_W_LOW:    n_phase = PH_W_TAIL;
                    PH_W_TAIL: begin
                        if (w_last_bit) begin
                            n_phase = PH_IDLE;
                            w_done  = 1'b1;
                        end else begin
                            n_bit   = w_bit + BIT_IDX_W'(1);
                            n_phase = PH_W_LOW;
                        end
                    end
                    PH_R_LOW:    n_phase = PH_R_WAIT;
                    PH_R_WAIT: begin
                        if (i_line_level) begin
                            n_shift[w_bit] = 1'b1;
                        end
                        n_phase = PH_R_REC;
                    end
                    PH_R_REC: begin
                        if (w_last_bit) begin
                            n_phase = PH_IDLE;
                            n_last  = w_shift;
                            w_done  = 1'b1;
                        end else begin
                            n_bit   = w_bit + BIT_IDX_W'(1);
                            n_phase = PH_R_LOW;
                        end
                    end
                    default:     n_phase = PH_IDLE;
                endcase
            end
        end

        o_res.drive_low  = (w_phase == PH_RST_LOW) || (w_phase == PH_W_LOW) ||
                           (w_phase == PH_R_LOW);
        o_res.busy       = w_phase != PH_IDLE;
        o_res.done       = w_done;
        o_res.presence   = n_pres;
        o_res.read_value = n_last;
    end

    assign o_status.busy = r_phase != PH_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pres  <= 1'b0;
            r_last  <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_last  <= n_last;
        end
    end

endmodule

`default_nettype wire
